// ===== sv/ordinal_time_offset_adder_core_assert.svh =====
// Assertion macros for the ordinal time offset adder.
`ifndef ORDINAL_TIME_OFFSET_ADDER_CORE_ASSERT_SVH
`define ORDINAL_TIME_OFFSET_ADDER_CORE_ASSERT_SVH

// Same-cycle implication, idle under reset
`define OTOA_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("otoa: same-cycle check failed");

// Next-cycle implication, idle under reset
`define OTOA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("otoa: next-cycle check failed");

`endif

// ===== sv/otoa_pkg.sv =====
package otoa_pkg;

    // Pipeline shape
    localparam int NUM_STAGES = 7;
    localparam int ST_FRAC    = 0;
    localparam int ST_SEC     = 1;
    localparam int ST_MIN     = 2;
    localparam int ST_HOUR    = 3;
    localparam int ST_YR0     = 4;
    localparam int ST_YR1     = 5;
    localparam int ST_OUT     = 6;

    // Bus widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;

    // Leap bits cover year offsets -YR_SPAN .. YR_SPAN-1
    localparam int YR_SPAN = 4;

    // Working item carried down the pipeline; fields fill in stage by stage
    typedef struct packed {
        logic [13:0]        year;
        logic signed [11:0] day;
        logic signed [7:0]  hour;
        logic signed [8:0]  minute;
        logic signed [8:0]  second;
        logic [13:0]        fraction;
        logic [8:0]         yfold;   // value congruent to year mod 25, 10..273
        logic [3:0]         yquot;   // yfold / 25
        logic [4:0]         yrem;    // year mod 25
        logic [7:0]         leap;    // leap flag of year + (j - YR_SPAN)
        logic signed [3:0]  yoff;    // years stepped so far
        logic               oor;
    } stage_t;

    // Form raw sums, normalise the fraction and fold the year modulo 25
    function automatic stage_t split_in(
        input logic [13:0]        s_year,
        input logic [8:0]         s_day,
        input logic [4:0]         s_hour,
        input logic [5:0]         s_minute,
        input logic [5:0]         s_second,
        input logic [13:0]        s_fraction,
        input logic signed [9:0]  o_days,
        input logic signed [5:0]  o_hours,
        input logic signed [6:0]  o_minutes,
        input logic signed [6:0]  o_seconds,
        input logic signed [14:0] o_fraction
    );
        stage_t             s;
        logic signed [15:0] fsum;
        logic signed [15:0] fnorm;
        logic signed [2:0]  fc;
        logic [9:0]         fold;
        s    = '0;
        fsum = $signed({2'b00, s_fraction}) + $signed({o_fraction[14], o_fraction});
        // floor carry of the fraction, sum lies in -16384..32766
        if (fsum < -16'sd10000) begin
            fc    = -3'sd2;
            fnorm = fsum + 16'sd20000;
        end else if (fsum < 16'sd0) begin
            fc    = -3'sd1;
            fnorm = fsum + 16'sd10000;
        end else if (fsum < 16'sd10000) begin
            fc    = 3'sd0;
            fnorm = fsum;
        end else if (fsum < 16'sd20000) begin
            fc    = 3'sd1;
            fnorm = fsum - 16'sd10000;
        end else if (fsum < 16'sd30000) begin
            fc    = 3'sd2;
            fnorm = fsum - 16'sd20000;
        end else begin
            fc    = 3'sd3;
            fnorm = fsum - 16'sd30000;
        end
        s.fraction = fnorm[13:0];
        s.second   = $signed({3'b000, s_second}) + $signed({{2{o_seconds[6]}}, o_seconds})
                   + $signed({{6{fc[2]}}, fc});
        s.minute   = $signed({3'b000, s_minute}) + $signed({{2{o_minutes[6]}}, o_minutes});
        s.hour     = $signed({3'b000, s_hour}) + $signed({{2{o_hours[5]}}, o_hours});
        s.day      = $signed({3'b000, s_day}) + $signed({{2{o_days[9]}}, o_days});
        s.year     = s_year;
        // 1024 = -1 and 32 = 7 modulo 25
        fold = {2'b00, s_year[9:5], 3'b000} - {5'b00000, s_year[9:5]}
             + {5'b00000, s_year[4:0]} + 10'd25 - {6'b000000, s_year[13:10]};
        s.yfold = fold[8:0];
        return s;
    endfunction

    // Normalise seconds into the minute; estimate yfold / 25
    function automatic stage_t norm_second(input stage_t p);
        stage_t            s;
        logic signed [2:0] c;
        logic [14:0]       prod;
        s = p;
        if (p.second < -9'sd60) begin
            c        = -3'sd2;
            s.second = p.second + 9'sd120;
        end else if (p.second < 9'sd0) begin
            c        = -3'sd1;
            s.second = p.second + 9'sd60;
        end else if (p.second < 9'sd60) begin
            c        = 3'sd0;
            s.second = p.second;
        end else if (p.second < 9'sd120) begin
            c        = 3'sd1;
            s.second = p.second - 9'sd60;
        end else begin
            c        = 3'sd2;
            s.second = p.second - 9'sd120;
        end
        s.minute = p.minute + $signed({{6{c[2]}}, c});
        // 41/1024 is exact enough for yfold below 400
        prod    = {6'b000000, p.yfold} * 15'd41;
        s.yquot = prod[13:10];
        return s;
    endfunction

    // Normalise minutes into the hour; finish year mod 25
    function automatic stage_t norm_minute(input stage_t p);
        stage_t            s;
        logic signed [2:0] c;
        logic [8:0]        rem;
        s = p;
        if (p.minute < -9'sd60) begin
            c        = -3'sd2;
            s.minute = p.minute + 9'sd120;
        end else if (p.minute < 9'sd0) begin
            c        = -3'sd1;
            s.minute = p.minute + 9'sd60;
        end else if (p.minute < 9'sd60) begin
            c        = 3'sd0;
            s.minute = p.minute;
        end else if (p.minute < 9'sd120) begin
            c        = 3'sd1;
            s.minute = p.minute - 9'sd60;
        end else begin
            c        = 3'sd2;
            s.minute = p.minute - 9'sd120;
        end
        s.hour = p.hour + $signed({{5{c[2]}}, c});
        rem    = p.yfold - {1'b0, p.yquot, 4'b0000} - {2'b00, p.yquot, 3'b000}
               - {5'b00000, p.yquot};
        s.yrem = rem[4:0];
        return s;
    endfunction

    // Normalise hours into the day; build leap flags around the start year
    function automatic stage_t norm_hour(input stage_t p);
        stage_t            s;
        logic signed [2:0] c;
        logic signed [5:0] kk;
        logic signed [5:0] rk;
        logic [3:0]        low4;
        logic              z25;
        s = p;
        if (p.hour < -8'sd24) begin
            c      = -3'sd2;
            s.hour = p.hour + 8'sd48;
        end else if (p.hour < 8'sd0) begin
            c      = -3'sd1;
            s.hour = p.hour + 8'sd24;
        end else if (p.hour < 8'sd24) begin
            c      = 3'sd0;
            s.hour = p.hour;
        end else if (p.hour < 8'sd48) begin
            c      = 3'sd1;
            s.hour = p.hour - 8'sd24;
        end else begin
            c      = 3'sd2;
            s.hour = p.hour - 8'sd48;
        end
        s.day = p.day + $signed({{9{c[2]}}, c});
        // leap: divisible by 4, and not by 100 unless by 400 (100 = 4*25, 400 = 16*25)
        for (int j = 0; j < 2 * YR_SPAN; j++) begin
            kk        = 6'(j - YR_SPAN);
            rk        = $signed({1'b0, p.yrem}) + kk;
            low4      = p.year[3:0] + kk[3:0];
            z25       = (rk == 6'sd0) || (rk == 6'sd25);
            s.leap[j] = (low4[1:0] == 2'b00) && (!z25 || (low4 == 4'b0000));
        end
        s.yoff = 4'sd0;
        return s;
    endfunction

    // One carry or borrow of the day into the year
    function automatic stage_t year_step(input stage_t p);
        stage_t             s;
        logic signed [3:0]  ic;
        logic [2:0]         icur;
        logic [2:0]         iprev;
        logic signed [11:0] len_cur;
        logic signed [11:0] len_prev;
        s        = p;
        ic       = p.yoff + 4'sd4;
        icur     = ic[2:0];
        iprev    = icur - 3'd1;
        len_cur  = p.leap[icur] ? 12'sd366 : 12'sd365;
        len_prev = p.leap[iprev] ? 12'sd366 : 12'sd365;
        if (p.day > len_cur) begin
            s.day  = p.day - len_cur;
            s.yoff = p.yoff + 4'sd1;
        end else if (p.day < 12'sd1) begin
            s.day  = p.day + len_prev;
            s.yoff = p.yoff - 4'sd1;
        end
        return s;
    endfunction

    // Apply the year offset and saturate
    function automatic stage_t finish_year(input stage_t p);
        stage_t             s;
        logic signed [15:0] y;
        s = p;
        y = $signed({2'b00, p.year}) + $signed({{12{p.yoff[3]}}, p.yoff});
        if (y < 16'sd1) begin
            s.year = 14'd1;
            s.oor  = 1'b1;
        end else if (y > 16'sd9999) begin
            s.year = 14'd9999;
            s.oor  = 1'b1;
        end else begin
            s.year = y[13:0];
            s.oor  = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== sv/ordinal_time_offset_adder_core.sv =====
// Channel   Dir  tdata (low bit up)                                tuser
// s_axis    in   start fields, then offset fields, padded to 104   -
// m_axis    out  sum fields, padded to 56                          year_out_of_range
//
// Seven register stages: fraction, second, minute and hour normalisation,
// two stages of two year carry steps each, and the output register.
// One transaction per cycle while m_axis accepts results.
// rst_n clears the stage valid bits only; payload registers hold no reset.
// A stall on m_axis backs up through empty-slot ready logic; no transaction is
// dropped or repeated.

`include "ordinal_time_offset_adder_core_assert.svh"

module ordinal_time_offset_adder_core
    import otoa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_year, start_day, start_hour, start_minute, start_second,
    // start_fraction, offset_days, offset_hours, offset_minutes,
    // offset_seconds, offset_fraction
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sum_year, sum_day, sum_hour, sum_minute, sum_second, sum_fraction
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // year_out_of_range
    output logic [0:0]           m_axis_tuser
);

    stage_t                  st_reg  [NUM_STAGES];
    stage_t                  st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   vld_next;
    logic [NUM_STAGES-1:0]   adv;
    logic                    yr1_settled;
    logic                    sum_in_range;
    logic                    sum_year_at_limit;

    // Advance a stage when it is empty or the one after it advances
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[ST_FRAC];

    // Stage logic
    always_comb
    begin
        st_next[ST_FRAC] = split_in(
            s_axis_tdata[13:0],  s_axis_tdata[22:14], s_axis_tdata[27:23],
            s_axis_tdata[33:28], s_axis_tdata[39:34], s_axis_tdata[53:40],
            $signed(s_axis_tdata[63:54]), $signed(s_axis_tdata[69:64]),
            $signed(s_axis_tdata[76:70]), $signed(s_axis_tdata[83:77]),
            $signed(s_axis_tdata[98:84]));
        st_next[ST_SEC]  = norm_second(st_reg[ST_FRAC]);
        st_next[ST_MIN]  = norm_minute(st_reg[ST_SEC]);
        st_next[ST_HOUR] = norm_hour(st_reg[ST_MIN]);
        st_next[ST_YR0]  = year_step(year_step(st_reg[ST_HOUR]));
        st_next[ST_YR1]  = year_step(year_step(st_reg[ST_YR0]));
        st_next[ST_OUT]  = finish_year(st_reg[ST_YR1]);
    end

    // Valid bits follow the data
    always_comb
    begin
        vld_next[ST_FRAC] = adv[ST_FRAC] ? s_axis_tvalid : vld_reg[ST_FRAC];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load payload on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Drive the result bus
    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {2'b00,
                            st_reg[ST_OUT].fraction,
                            st_reg[ST_OUT].second[5:0],
                            st_reg[ST_OUT].minute[5:0],
                            st_reg[ST_OUT].hour[4:0],
                            st_reg[ST_OUT].day[8:0],
                            st_reg[ST_OUT].year};
    assign m_axis_tuser  = st_reg[ST_OUT].oor;

    // Conditions watched by the checks
    assign yr1_settled       = st_reg[ST_YR1].day >= 12'sd1 && st_reg[ST_YR1].day <= 12'sd366
                               && st_reg[ST_YR1].yoff >= -4'sd2
                               && st_reg[ST_YR1].yoff <= 4'sd2;
    assign sum_in_range      = m_axis_tdata[27:23] < 5'd24 && m_axis_tdata[33:28] < 6'd60
                               && m_axis_tdata[39:34] < 6'd60
                               && m_axis_tdata[53:40] < 14'd10000;
    assign sum_year_at_limit = m_axis_tdata[13:0] == 14'd1 || m_axis_tdata[13:0] == 14'd9999;

    // Checks
    `OTOA_ASSERT_NEXT(a_load_first, clk, rst_n, s_axis_tvalid && s_axis_tready, vld_reg[ST_FRAC])
    `OTOA_ASSERT_IMPLIES(a_year_settled, clk, rst_n, vld_reg[ST_YR1], yr1_settled)
    `OTOA_ASSERT_IMPLIES(a_sum_normal, clk, rst_n, m_axis_tvalid, sum_in_range)
    `OTOA_ASSERT_IMPLIES(a_sat_flag, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], sum_year_at_limit)

endmodule
